/* rtl/core/sppb_pkg.sv */
// ----------------------------------------------------------------------------
// Serial peek/poke bridge package
// Job codes and the job record passed from the command parser to the
// message sequencer.
// ----------------------------------------------------------------------------
package sppb_pkg;

  localparam int JOB_KIND_W = 3;

  // Work that one parsed input leaves for the sequencer.
  localparam logic [JOB_KIND_W-1:0] JOB_BAD_CMD  = 3'd0;
  localparam logic [JOB_KIND_W-1:0] JOB_BAD_ADDR = 3'd1;
  localparam logic [JOB_KIND_W-1:0] JOB_READ     = 3'd2;
  localparam logic [JOB_KIND_W-1:0] JOB_WRITE    = 3'd3;
  localparam logic [JOB_KIND_W-1:0] JOB_BAD_DATA = 3'd4;
  localparam logic [JOB_KIND_W-1:0] JOB_PEEK     = 3'd5;

  typedef struct packed {
    logic [JOB_KIND_W-1:0] kind;
    logic [31:0]           addr;
    logic [31:0]           data;
  } job_t;

  // Queue status seen by the parser and the sequencer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/sppb_if.sv */
// ----------------------------------------------------------------------------
// Serial peek/poke bridge channels
// Valid/ready interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface sppb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  rx_byte;
  logic [31:0] read_data;

  modport source (output valid, func, rx_byte, read_data, input ready);
  modport sink   (input valid, func, rx_byte, read_data, output ready);
endinterface

interface sppb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [31:0] bus_address;
  logic [31:0] bus_write_data;
  logic        last;

  modport source (output valid, kind, tx_byte, bus_address, bus_write_data, last,
                  input ready);
  modport sink   (input valid, kind, tx_byte, bus_address, bus_write_data, last,
                  output ready);
endinterface

/* rtl/core/sppb_front.sv */
// ----------------------------------------------------------------------------
// Serial peek/poke bridge command parser
// Accepts one transaction per cycle while the queue has room, tracks the
// command, address and data fields, and posts one job per input with a result.
// ----------------------------------------------------------------------------
module sppb_front #(
  parameter int HEX_DIGITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sppb_in_if.sink                in_ch,
  input  sppb_pkg::queue_status_t q_status,
  output logic                   push,
  output sppb_pkg::job_t         push_job
);
  import sppb_pkg::*;

  localparam int FIELD_LEN = HEX_DIGITS + 2;
  localparam int CW        = $clog2(FIELD_LEN) < 2 ? 2 : $clog2(FIELD_LEN);

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  localparam logic [31:0] WORD_PEEK = "peek";
  localparam logic [31:0] WORD_POKE = "poke";

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) v = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) v = {1'b0, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          is_poke_r, is_poke_nxt;
  logic [1:0]    match_r, match_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic          addr_ok_r, addr_ok_nxt;
  logic [31:0]   data_r, data_nxt;
  logic          data_ok_r, data_ok_nxt;

  logic          accept;
  logic [4:0]    digit;
  logic          in_window;
  logic          field_end;
  logic [1:0]    m;
  logic [1:0]    k;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign digit       = hex_decode(in_ch.rx_byte);
  assign in_window   = (cnt_r >= CW'(1)) && (cnt_r <= CW'(HEX_DIGITS));
  assign field_end   = (cnt_r == CW'(FIELD_LEN - 1));
  assign k           = cnt_r[1:0];

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    is_poke_nxt = is_poke_r;
    match_nxt   = match_r;
    addr_nxt    = addr_r;
    addr_ok_nxt = addr_ok_r;
    data_nxt    = data_r;
    data_ok_nxt = data_ok_r;
    push        = 1'b0;
    push_job    = '{kind: JOB_BAD_CMD, addr: addr_r, data: data_r};
    m           = match_r;

    if (accept) begin
      if (in_ch.func) begin
        if (phase_r == PH_WAIT) begin
          push          = 1'b1;
          push_job.kind = JOB_PEEK;
          push_job.data = in_ch.read_data;
          phase_nxt     = PH_CMD;
          cnt_nxt       = '0;
          match_nxt     = 2'b11;
        end
      end else begin
        case (phase_r)
          PH_CMD: begin
            if (in_ch.rx_byte != WORD_PEEK[{~k, 3'b000} +: 8]) m[0] = 1'b0;
            if (in_ch.rx_byte != WORD_POKE[{~k, 3'b000} +: 8]) m[1] = 1'b0;
            if (k == 2'd3) begin
              cnt_nxt     = '0;
              addr_nxt    = '0;
              addr_ok_nxt = 1'b1;
              data_nxt    = '0;
              data_ok_nxt = 1'b1;
              match_nxt   = 2'b11;
              if (m[0]) begin
                is_poke_nxt = 1'b0;
                phase_nxt   = PH_ADDR;
              end else if (m[1]) begin
                is_poke_nxt = 1'b1;
                phase_nxt   = PH_ADDR;
              end else begin
                push          = 1'b1;
                push_job.kind = JOB_BAD_CMD;
              end
            end else begin
              cnt_nxt   = cnt_r + CW'(1);
              match_nxt = m;
            end
          end
          PH_ADDR: begin
            if (in_window) begin
              if (digit[4]) addr_ok_nxt = 1'b0;
              else addr_nxt = {addr_r[27:0], digit[3:0]};
            end
            if (field_end) begin
              cnt_nxt = '0;
              if (is_poke_r) begin
                phase_nxt = PH_DATA;
              end else begin
                if (!addr_ok_nxt) begin
                  push          = 1'b1;
                  push_job.kind = JOB_BAD_ADDR;
                  phase_nxt     = PH_CMD;
                end else if (addr_nxt == 32'd0) begin
                  phase_nxt = PH_CMD;
                end else begin
                  push          = 1'b1;
                  push_job.kind = JOB_READ;
                  push_job.addr = addr_nxt;
                  phase_nxt     = PH_WAIT;
                end
                match_nxt = 2'b11;
              end
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          PH_DATA: begin
            if (in_window) begin
              if (digit[4]) data_ok_nxt = 1'b0;
              else data_nxt = {data_r[27:0], digit[3:0]};
            end
            if (field_end) begin
              if (!addr_ok_r) begin
                push          = 1'b1;
                push_job.kind = JOB_BAD_ADDR;
              end else if (addr_r != 32'd0) begin
                push = 1'b1;
                if (data_ok_nxt) begin
                  push_job.kind = JOB_WRITE;
                  push_job.data = data_nxt;
                end else begin
                  push_job.kind = JOB_BAD_DATA;
                  push_job.data = '0;
                end
              end
              phase_nxt = PH_CMD;
              cnt_nxt   = '0;
              match_nxt = 2'b11;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          default: begin
            // Serial bytes while a read is outstanding are dropped.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD;
      cnt_r     <= '0;
      is_poke_r <= 1'b0;
      match_r   <= 2'b11;
      addr_r    <= '0;
      addr_ok_r <= 1'b1;
      data_r    <= '0;
      data_ok_r <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      is_poke_r <= is_poke_nxt;
      match_r   <= match_nxt;
      addr_r    <= addr_nxt;
      addr_ok_r <= addr_ok_nxt;
      data_r    <= data_nxt;
      data_ok_r <= data_ok_nxt;
    end
  end

endmodule

/* rtl/core/sppb_job_fifo.sv */
// ----------------------------------------------------------------------------
// Serial peek/poke bridge job queue
// Short register queue between the parser and the message sequencer.
// ----------------------------------------------------------------------------
module sppb_job_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sppb_pkg::job_t          push_job,
  input  logic                    pop,
  output sppb_pkg::job_t          head_job,
  output sppb_pkg::queue_status_t status
);
  import sppb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  job_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == NW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop) count_nxt = count_r + NW'(1);
    else if (pop && !push) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job popped from an empty queue");

  a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + NW'(1)))
    else $error("queue fill count lost a push");

endmodule

/* rtl/core/sppb_back.sv */
// ----------------------------------------------------------------------------
// Serial peek/poke bridge message sequencer
// Expands the job at the head of the queue into result transactions, one
// per cycle while the sink accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
module sppb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sppb_pkg::job_t          head_job,
  input  sppb_pkg::queue_status_t q_status,
  output logic                    pop,
  sppb_out_if.source              out_ch
);
  import sppb_pkg::*;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam int LEN_BAD_CMD  = 21;
  localparam int LEN_BAD_ADDR = 14;
  localparam int LEN_BAD_DATA = 14;
  localparam int LEN_DONE     = 25;
  localparam int PEEK_DIGITS  = 8;

  localparam logic [8*LEN_BAD_CMD-1:0]  TXT_BAD_CMD  = {"INVALID INSTRUCTION!", 8'h00};
  localparam logic [8*LEN_BAD_ADDR-1:0] TXT_BAD_ADDR = {"INVALID ADDR!", 8'h00};
  localparam logic [8*LEN_BAD_DATA-1:0] TXT_BAD_DATA = {"INVALID DATA!", 8'h00};
  localparam logic [8*LEN_DONE-1:0]     TXT_DONE     = {8'h0A, "DONE! EVERYTHING IS OK!",
                                                        8'h00};
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        last;
  } item_t;

  function automatic logic [7:0] bad_cmd_char(logic [4:0] p);
    logic [4:0] r;
    r = 5'(LEN_BAD_CMD - 1) - p;
    return TXT_BAD_CMD[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] bad_addr_char(logic [3:0] p);
    logic [3:0] r;
    r = 4'(LEN_BAD_ADDR - 1) - p;
    return TXT_BAD_ADDR[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] bad_data_char(logic [3:0] p);
    logic [3:0] r;
    r = 4'(LEN_BAD_DATA - 1) - p;
    return TXT_BAD_DATA[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] done_char(logic [4:0] p);
    logic [4:0] r;
    r = 5'(LEN_DONE - 1) - p;
    return TXT_DONE[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (HEX_ALPHA_BASE + {4'd0, d});
  endfunction

  logic [5:0] idx_r;
  logic       out_valid_r;
  item_t      out_r;
  item_t      itm;
  logic       load;
  logic [5:0] off1, off2, off10, off15;
  logic [2:0] nib;

  assign off1  = idx_r - 6'd1;
  assign off2  = idx_r - 6'd2;
  assign off10 = idx_r - 6'd10;
  assign off15 = idx_r - 6'd15;
  assign nib   = 3'(PEEK_DIGITS - 1) - off2[2:0];

  always_comb begin
    itm = '{kind: KIND_TX, tx: 8'h00, addr: 32'd0, wdata: 32'd0, last: 1'b0};
    case (head_job.kind)
      JOB_BAD_CMD: begin
        itm.tx   = bad_cmd_char(idx_r[4:0]);
        itm.last = (idx_r == 6'(LEN_BAD_CMD - 1));
      end
      JOB_BAD_ADDR: begin
        itm.tx   = bad_addr_char(idx_r[3:0]);
        itm.last = (idx_r == 6'(LEN_BAD_ADDR - 1));
      end
      JOB_READ: begin
        itm.kind = KIND_READ;
        itm.addr = head_job.addr;
        itm.last = 1'b1;
      end
      JOB_WRITE: begin
        if (idx_r == 6'd0) begin
          itm.kind  = KIND_WRITE;
          itm.addr  = head_job.addr;
          itm.wdata = head_job.data;
        end else begin
          itm.tx = done_char(off1[4:0]);
        end
        itm.last = (idx_r == 6'(LEN_DONE));
      end
      JOB_BAD_DATA: begin
        if (idx_r < 6'(LEN_BAD_DATA)) begin
          itm.tx = bad_data_char(idx_r[3:0]);
        end else if (idx_r == 6'(LEN_BAD_DATA)) begin
          itm.kind  = KIND_WRITE;
          itm.addr  = head_job.addr;
          itm.wdata = head_job.data;
        end else begin
          itm.tx = done_char(off15[4:0]);
        end
        itm.last = (idx_r == 6'(LEN_BAD_DATA + LEN_DONE));
      end
      JOB_PEEK: begin
        if (idx_r == 6'd0) itm.tx = 8'h30;
        else if (idx_r == 6'd1) itm.tx = 8'h78;
        else if (idx_r < 6'(PEEK_DIGITS + 2)) itm.tx = hex_char(head_job.data[{nib, 2'b00} +: 4]);
        else itm.tx = done_char(off10[4:0]);
        itm.last = (idx_r == 6'(PEEK_DIGITS + 2 + LEN_DONE - 1));
      end
      default: begin
        itm.last = 1'b1;
      end
    endcase
  end

  assign load = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign pop  = load && itm.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= itm.last ? 6'd0 : idx_r + 6'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= itm;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.tx_byte        = out_r.tx;
  assign out_ch.bus_address    = out_r.addr;
  assign out_ch.bus_write_data = out_r.wdata;
  assign out_ch.last           = out_r.last;

endmodule

/* rtl/core/serial_peek_poke_command_bridge_core.sv */
// Path: each job is registered in the queue; the message sequencer behind it
//   registers results in the output stage, one per cycle with a ready sink.
// Throughput: one input per cycle while the job queue has room; output rate is
//   one result per cycle with a ready sink, set by the single message sequencer.
// Reset: rst_n is synchronous and active low; it returns the parser to the
//   command word, empties the queue and drops any result in the output stage.
// ----------------------------------------------------------------------------
// Serial peek/poke bridge core
// Parses peek/poke command text from a serial byte stream and turns it into
// bus read and write requests and reply text.
// ----------------------------------------------------------------------------
module serial_peek_poke_command_bridge_core #(
  parameter int HEX_DIGITS  = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  sppb_in_if.sink    in_ch,
  sppb_out_if.source out_ch
);
  import sppb_pkg::*;

  // The front end sees every input transaction. Each one that produces any
  // result leaves exactly one job in the queue, so the last flag of a job's
  // final result also marks the last result of that input.
  job_t          push_job;
  job_t          head_job;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  // Parser: command word matching, hex field accumulation and the
  // outstanding-read wait. It holds ready low only when the queue is full.
  sppb_front #(
    .HEX_DIGITS (HEX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Short queue so that parsing carries on while a long reply text drains.
  sppb_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Sequencer: walks the head job one result per cycle while the sink is ready
  // into the output register, which doubles as skid stage for a stalled sink.
  sppb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
